// ----- hw/rtl/yrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package yrc_pkg;

  localparam int unsigned MAX_PAIRS_DEF = 1024;
  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] PAIRS_RESET = 11'd320;

  localparam int unsigned TERM_W = 22;
  localparam int unsigned FRAC_W = 10;

  typedef logic [7:0] pix_t;
  typedef logic [CFG_W-1:0] pairs_t;
  typedef logic signed [TERM_W-1:0] term_t;

  localparam term_t LUMA_COEF = 22'sd1192;
  localparam term_t BU_COEF = 22'sd2066;
  localparam term_t GV_COEF = 22'sd833;
  localparam term_t GU_COEF = 22'sd400;
  localparam term_t RV_COEF = 22'sd1634;
  localparam term_t LUMA_OFFSET = 22'sd16;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

  typedef struct packed {
    logic eor;
    pix_t u;
    pix_t v;
  } chroma_word_t;

  typedef struct packed {
    term_t r;
    term_t g;
    term_t b;
  } chroma_terms_t;

endpackage
`default_nettype wire

// ----- hw/rtl/yrc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface yrc_in_if import yrc_pkg::*; ();
  logic valid;
  logic ready;
  logic first_of_frame;
  pix_t luma_left;
  pix_t luma_right;
  pix_t chroma_u;
  pix_t chroma_v;

  modport source (
    output valid, first_of_frame, luma_left, luma_right, chroma_u, chroma_v,
    input ready
  );
  modport sink (
    input valid, first_of_frame, luma_left, luma_right, chroma_u, chroma_v,
    output ready
  );
endinterface

interface yrc_out_if import yrc_pkg::*; ();
  logic valid;
  logic ready;
  pix_t red_left;
  pix_t green_left;
  pix_t blue_left;
  pix_t red_right;
  pix_t green_right;
  pix_t blue_right;
  logic end_of_row;

  modport source (
    output valid, red_left, green_left, blue_left, red_right, green_right, blue_right,
    output end_of_row,
    input ready
  );
  modport sink (
    input valid, red_left, green_left, blue_left, red_right, green_right, blue_right,
    input end_of_row,
    output ready
  );
endinterface

interface yrc_cfg_if import yrc_pkg::*; ();
  logic valid;
  logic ready;
  pairs_t pairs_per_row;

  modport source (
    output valid, pairs_per_row,
    input ready
  );
  modport sink (
    input valid, pairs_per_row,
    output ready
  );
endinterface
`default_nettype wire

// ----- hw/rtl/yrc_line_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module yrc_line_ctrl import yrc_pkg::*; #(
  parameter int unsigned MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          fire,
  input  wire          en1,
  input  wire          first_of_frame,
  input  pix_t         chroma_u,
  input  pix_t         chroma_v,
  input  pairs_t       pairs_per_row,
  output chroma_word_t s1
);

  localparam int unsigned CW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned PW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam logic [PW-1:0] MAX_P = PW'(MAX_PAIRS);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  logic [15:0]   mem [MAX_PAIRS];
  logic [15:0]   rd_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic          odd_r;
  logic          odd_nxt;
  logic          odd1_r;
  logic          eor1_r;
  pix_t          u1_r;
  pix_t          v1_r;

  logic [PW-1:0] pairs_ext;
  logic [PW-1:0] plim;
  logic [CW-1:0] last;
  logic [CW-1:0] col_cur;
  logic          odd_cur;
  logic [CW-1:0] col;
  logic          eor;

  always_comb begin
    pairs_ext = PW'(pairs_per_row);
    if (pairs_ext == '0) begin
      plim = ONE_P;
    end else if (pairs_ext > MAX_P) begin
      plim = MAX_P;
    end else begin
      plim = pairs_ext;
    end
    last = CW'(plim - ONE_P);
    col_cur = first_of_frame ? '0 : col_r;
    odd_cur = first_of_frame ? 1'b0 : odd_r;
    col = (col_cur >= last) ? last : col_cur;
    eor = (col == last);
    if (eor) begin
      col_nxt = '0;
      odd_nxt = ~odd_cur;
    end else begin
      col_nxt = col + CW'(1);
      odd_nxt = odd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
    end else if (fire) begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !odd_cur) begin
      mem[col] <= {chroma_u, chroma_v};
    end
    if (en1) begin
      rd_r <= mem[col];
      odd1_r <= odd_cur;
      eor1_r <= eor;
      u1_r <= chroma_u;
      v1_r <= chroma_v;
    end
  end

  assign s1.eor = eor1_r;
  assign s1.u = odd1_r ? rd_r[15:8] : u1_r;
  assign s1.v = odd1_r ? rd_r[7:0] : v1_r;

endmodule
`default_nettype wire

// ----- hw/rtl/yrc_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
module yrc_lane import yrc_pkg::*; (
  input  wire           clk,
  input  wire           en2,
  input  wire           en3,
  input  pix_t          luma,
  input  chroma_terms_t terms,
  output rgb_t          rgb
);

  term_t c_r;
  term_t luma_s;
  rgb_t  rgb_r;
  rgb_t  rgb_nxt;

  function automatic pix_t clamp8(input term_t s);
    pix_t q;
    begin
      if (s[TERM_W-1]) begin
        q = '0;
      end else if (|s[TERM_W-2:FRAC_W+8]) begin
        q = 8'hFF;
      end else begin
        q = s[FRAC_W+7:FRAC_W];
      end
      return q;
    end
  endfunction

  always_comb begin
    luma_s = term_t'({1'b0, luma}) - LUMA_OFFSET;
    rgb_nxt.r = clamp8(c_r + terms.r);
    rgb_nxt.g = clamp8(c_r + terms.g);
    rgb_nxt.b = clamp8(c_r + terms.b);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      c_r <= luma_s * LUMA_COEF;
    end
    if (en3) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign rgb = rgb_r;

endmodule
`default_nettype wire

// ----- hw/rtl/yuv420_to_rgb_converter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Three register stages (line store read, chroma terms with luma product, clamped
// RGB); an accepted word passes through them in that order to the output.
// Throughput: one pixel pair per cycle unless the output stalls, set by the two
// conversion lanes and the chroma store, read per word and written on even rows.
// Reset (synchronous, active low) clears the column, the row parity and the
// stage valids, and sets pairs_per_row to 320; the chroma store is not cleared.
module yuv420_to_rgb_converter import yrc_pkg::*; #(
  parameter int unsigned MAX_PAIRS = MAX_PAIRS_DEF
) (
  input wire        clk,
  input wire        rst_n,
  yrc_in_if.sink    in_ch,
  yrc_out_if.source out_ch,
  yrc_cfg_if.sink   cfg_ch
);

  pairs_t        pairs_r;
  logic          v1_r;
  logic          v2_r;
  logic          v3_r;
  logic          eor2_r;
  logic          eor3_r;
  logic          rdy1;
  logic          rdy2;
  logic          rdy3;
  logic          in_fire;
  chroma_word_t  s1;
  chroma_terms_t terms_r;
  chroma_terms_t terms_nxt;
  term_t         d_s;
  term_t         e_s;
  pix_t          y_l_r;
  pix_t          y_r_r;
  rgb_t          rgb_l;
  rgb_t          rgb_r;

  assign rdy3 = !v3_r || out_ch.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;
  assign in_fire = in_ch.valid && rdy1;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= PAIRS_RESET;
    end else if (cfg_ch.valid) begin
      pairs_r <= cfg_ch.pairs_per_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  yrc_line_ctrl #(
    .MAX_PAIRS(MAX_PAIRS)
  ) u_line_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .en1           (rdy1),
    .first_of_frame(in_ch.first_of_frame),
    .chroma_u      (in_ch.chroma_u),
    .chroma_v      (in_ch.chroma_v),
    .pairs_per_row (pairs_r),
    .s1            (s1)
  );

  // Flipping the top bit of an offset-binary sample gives its signed value.
  always_comb begin
    d_s = term_t'($signed(s1.u ^ 8'h80));
    e_s = term_t'($signed(s1.v ^ 8'h80));
    terms_nxt.r = RV_COEF * e_s;
    terms_nxt.g = -(GV_COEF * e_s) - (GU_COEF * d_s);
    terms_nxt.b = BU_COEF * d_s;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      y_l_r <= in_ch.luma_left;
      y_r_r <= in_ch.luma_right;
    end
    if (rdy2) begin
      terms_r <= terms_nxt;
      eor2_r <= s1.eor;
    end
    if (rdy3) begin
      eor3_r <= eor2_r;
    end
  end

  yrc_lane u_lane_left (
    .clk  (clk),
    .en2  (rdy2),
    .en3  (rdy3),
    .luma (y_l_r),
    .terms(terms_r),
    .rgb  (rgb_l)
  );

  yrc_lane u_lane_right (
    .clk  (clk),
    .en2  (rdy2),
    .en3  (rdy3),
    .luma (y_r_r),
    .terms(terms_r),
    .rgb  (rgb_r)
  );

  assign out_ch.valid = v3_r;
  assign out_ch.red_left = rgb_l.r;
  assign out_ch.green_left = rgb_l.g;
  assign out_ch.blue_left = rgb_l.b;
  assign out_ch.red_right = rgb_r.r;
  assign out_ch.green_right = rgb_r.g;
  assign out_ch.blue_right = rgb_r.b;
  assign out_ch.end_of_row = eor3_r;

`ifndef ASSERT_OFF
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v1_r)
    else $error("accepted word did not enter the first stage");

  a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && rdy2) |=> v2_r)
    else $error("word lost between the first and second stage");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ch.ready) |=> (v3_r && $stable(eor3_r)))
    else $error("stalled result was dropped or changed");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_yuv420_to_rgb_converter.sv -----
`timescale 1ns / 1ps
module tb_yuv420_to_rgb_converter;
  import yrc_pkg::*;

  localparam int PAIRS_MAX = 1024;
  localparam int K_LUMA = 1192;
  localparam int K_BU = 2066;
  localparam int K_GV = 833;
  localparam int K_GU = 400;
  localparam int K_RV = 1634;

  typedef struct packed {
    logic first;
    pix_t y_left;
    pix_t y_right;
    pix_t u;
    pix_t v;
  } yuv_word_t;

  typedef struct packed {
    rgb_t left;
    rgb_t right;
    logic eor;
  } rgb_word_t;

  logic clk = 1'b0;
  logic rst_n;

  yrc_in_if in_if ();
  yrc_out_if out_if ();
  yrc_cfg_if cfg_if ();

  yuv420_to_rgb_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #10 clk = ~clk;

  pix_t line_u [PAIRS_MAX];
  pix_t line_v [PAIRS_MAX];
  bit line_written [PAIRS_MAX];
  int col_pos = 0;
  bit odd_line = 1'b0;
  int pairs_cfg = 320;

  rgb_word_t expected_rgb [$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int odd_words = 0;
  bit idle_enable = 1'b1;
  int hold_request = 0;

  function automatic int effective_last();
    int last;
    last = pairs_cfg;
    if (last == 0) last = 1;
    if (last > PAIRS_MAX) last = PAIRS_MAX;
    return last - 1;
  endfunction

  function automatic int next_column();
    int c;
    c = col_pos;
    if (c > effective_last()) c = effective_last();
    return c;
  endfunction

  function automatic pix_t sat_byte(int s);
    int q;
    q = s >>> 10;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return pix_t'(q);
  endfunction

  function automatic rgb_t yuv_to_rgb(pix_t y, pix_t u, pix_t v);
    int luma;
    int du;
    int dv;
    rgb_t p;
    luma = K_LUMA * (int'(y) - 16);
    du = int'(u) - 128;
    dv = int'(v) - 128;
    p.r = sat_byte(luma + K_RV * dv);
    p.g = sat_byte(luma - K_GV * dv - K_GU * du);
    p.b = sat_byte(luma + K_BU * du);
    return p;
  endfunction

  function automatic rgb_word_t predict_rgb(yuv_word_t w);
    rgb_word_t r;
    int col;
    pix_t u;
    pix_t v;
    if (w.first) begin
      col_pos = 0;
      odd_line = 1'b0;
    end
    col = next_column();
    if (!odd_line) begin
      line_u[col] = w.u;
      line_v[col] = w.v;
      line_written[col] = 1'b1;
      u = w.u;
      v = w.v;
    end else begin
      u = line_u[col];
      v = line_v[col];
    end
    r.left = yuv_to_rgb(w.y_left, u, v);
    r.right = yuv_to_rgb(w.y_right, u, v);
    r.eor = (col == effective_last());
    if (r.eor) begin
      col_pos = 0;
      odd_line = ~odd_line;
    end else begin
      col_pos = col + 1;
    end
    return r;
  endfunction

  function automatic yuv_word_t random_word(bit first);
    yuv_word_t w;
    w.first = first;
    w.y_left = pix_t'($urandom_range(0, 255));
    w.y_right = pix_t'($urandom_range(0, 255));
    w.u = pix_t'($urandom_range(0, 255));
    w.v = pix_t'($urandom_range(0, 255));
    return w;
  endfunction

  task automatic send_word(yuv_word_t w);
    int gap;
    gap = idle_enable ? $urandom_range(0, 4) : 0;
    // An odd row must never read a column of the line store that no even row has filled.
    if (!w.first && odd_line && !line_written[next_column()]) w.first = 1'b1;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.first_of_frame <= w.first;
    in_if.luma_left <= w.y_left;
    in_if.luma_right <= w.y_right;
    in_if.chroma_u <= w.u;
    in_if.chroma_v <= w.v;
    do @(posedge clk); while (!in_if.ready);
    if (odd_line && !w.first) odd_words++;
    expected_rgb.push_back(predict_rgb(w));
    words_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_pairs(pairs_t n);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.pairs_per_row <= n;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pairs_cfg = int'(n);
  endtask

  task automatic send_random(int count);
    repeat (count) send_word(random_word(1'b0));
  endtask

  task automatic test_extremes();
    write_pairs(11'd2);
    send_word(yuv_word_t'{1'b1, 8'd0, 8'd255, 8'd0, 8'd255});
    send_word(yuv_word_t'{1'b0, 8'd255, 8'd0, 8'd255, 8'd0});
    send_word(yuv_word_t'{1'b0, 8'd16, 8'd235, 8'd128, 8'd128});
    send_word(yuv_word_t'{1'b0, 8'd128, 8'd1, 8'h55, 8'hAA});
    send_word(yuv_word_t'{1'b0, 8'd235, 8'd16, 8'd16, 8'd240});
    send_word(yuv_word_t'{1'b0, 8'd0, 8'd0, 8'd240, 8'd16});
    send_word(yuv_word_t'{1'b0, 8'd255, 8'd255, 8'd0, 8'd0});
    send_word(yuv_word_t'{1'b0, 8'd254, 8'd17, 8'd255, 8'd255});
    send_word(yuv_word_t'{1'b0, 8'd15, 8'd16, 8'd128, 8'd0});
    // A frame start in the middle of a row restarts the column and parity.
    send_word(yuv_word_t'{1'b1, 8'd200, 8'd100, 8'd255, 8'd128});
    send_word(yuv_word_t'{1'b0, 8'd100, 8'd200, 8'd128, 8'd255});
    send_word(yuv_word_t'{1'b0, 8'd50, 8'd60, 8'd0, 8'd0});
  endtask

  task automatic test_width_zero();
    write_pairs(11'd0);
    send_word(random_word(1'b1));
    send_random(3);
    write_pairs(11'd1);
    send_random(3);
  endtask

  task automatic test_width_change();
    write_pairs(11'd8);
    send_word(random_word(1'b1));
    send_random(4);
    write_pairs(11'd3);
    send_random(4);
    write_pairs(11'd4);
    send_random(2);
    write_pairs(11'd10);
    send_random(6);
  endtask

  task automatic test_widest_row();
    write_pairs(11'd1024);
    send_word(random_word(1'b1));
    send_random(1019);
    write_pairs(11'd2047);
    send_random(10);
    send_random(12);
  endtask

  task automatic test_backpressure();
    write_pairs(11'd16);
    send_word(random_word(1'b1));
    idle_enable = 1'b0;
    hold_request = 200;
    send_random(80);
    idle_enable = 1'b1;
  endtask

  task automatic test_random_frames();
    int width;
    for (int phase = 0; phase < 5; phase++) begin
      case ($urandom_range(0, 9))
        0: width = $urandom_range(0, 2047);
        1: width = 1;
        default: width = $urandom_range(1, 24);
      endcase
      write_pairs(pairs_t'(width));
      idle_enable = (phase % 4) != 3;
      send_word(random_word($urandom_range(0, 3) == 0));
      repeat (69) send_word(random_word($urandom_range(0, 199) == 0));
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_enable ? $urandom_range(0, 4) : 0;
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rgb_word_t want;
    rgb_word_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.red_left, out_if.green_left, out_if.blue_left,
             out_if.red_right, out_if.green_right, out_if.blue_right, out_if.end_of_row};
      if (expected_rgb.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
      end else begin
        want = expected_rgb.pop_front();
        words_checked++;
        check_field("red_left", want.left.r, got.left.r);
        check_field("green_left", want.left.g, got.left.g);
        check_field("blue_left", want.left.b, got.left.b);
        check_field("red_right", want.right.r, got.right.r);
        check_field("green_right", want.right.g, got.right.g);
        check_field("blue_right", want.right.b, got.right.b);
        check_field("end_of_row", 8'(want.eor), 8'(got.eor));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.first_of_frame <= 1'b0;
    in_if.luma_left <= '0;
    in_if.luma_right <= '0;
    in_if.chroma_u <= '0;
    in_if.chroma_v <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.pairs_per_row <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_width_zero();
    test_width_change();
    test_widest_row();
    test_backpressure();
    test_random_frames();
    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixel pairs and checked %0d words, %0d of them from stored chroma.",
             words_sent, words_checked, odd_words);
    $display("Row widths from zero to 2047, mid-row width changes and long output stalls.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
